@@ hw/rtl/bounded_window_subarray_counter_macros.svh @@
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef BOUNDED_WINDOW_SUBARRAY_COUNTER_MACROS_SVH
`define BOUNDED_WINDOW_SUBARRAY_COUNTER_MACROS_SVH

// Same-cycle implication.
`define BWSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BWSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bwsc_pkg.sv @@
package bwsc_pkg;

    localparam int LIMIT_W = 32;
    localparam int TOTAL_W = 48;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_FULL,
        ENG_DROP,
        ENG_FIN
    } eng_state_t;

endpackage

@@ hw/rtl/bwsc_if.sv @@
interface bwsc_in_if #(
    parameter int ELEMENT_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [ELEMENT_BITS-1:0] element;
    logic                    first;

    modport source (output valid, output element, output first, input ready);
    modport sink   (input valid, input element, input first, output ready);
endinterface

interface bwsc_out_if
    import bwsc_pkg::*;
#(
    parameter int LEN_W = 11
);
    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   ending_here;
    logic [TOTAL_W-1:0] running_total;
    logic               window_overflow;

    modport source (output valid, output ending_here, output running_total,
                    output window_overflow, input ready);
    modport sink   (input valid, input ending_here, input running_total,
                    input window_overflow, output ready);
endinterface

interface bwsc_cfg_if
    import bwsc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] sum_limit;

    modport source (output valid, output sum_limit, input ready);
    modport sink   (input valid, input sum_limit, output ready);
endinterface

@@ hw/rtl/bwsc_ram.sv @@
module bwsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bwsc_queue.sv @@
module bwsc_queue (
    input  logic      clk,
    input  logic      rst_n,
    bwsc_in_if.sink   up,
    bwsc_in_if.source down
);

    localparam int EW = $bits(up.element);

    logic [EW-1:0] elem_reg [2];
    logic          first_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign up.ready     = (cnt_reg != 2'd2);
    assign down.valid   = (cnt_reg != 2'd0);
    assign down.element = elem_reg[rd_ptr_reg];
    assign down.first   = first_reg[rd_ptr_reg];

    assign push = up.valid && up.ready;
    assign pop  = down.valid && down.ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            elem_reg[wr_ptr_reg]  <= up.element;
            first_reg[wr_ptr_reg] <= up.first;
        end
    end

endmodule

@@ hw/rtl/bwsc_engine.sv @@
module bwsc_engine
    import bwsc_pkg::*;
#(
    parameter int MAX_WINDOW   = 1024,
    parameter int ELEMENT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bwsc_in_if.sink    item,
    bwsc_out_if.source result,
    bwsc_cfg_if.sink   cfg
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = ELEMENT_BITS + LEN_W;
    localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);
    localparam logic [LEN_W:0]   WRAP     = (LEN_W + 1)'(MAX_WINDOW);

    eng_state_t state_reg, state_next;

    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic                    ovf_reg, ovf_next;
    logic [LIMIT_W-1:0]      limit_reg;
    logic [ELEMENT_BITS-1:0] elem_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]        out_len_reg;
    logic [TOTAL_W-1:0]      out_total_reg;
    logic                    out_ovf_reg;

    logic [PTR_W-1:0]        c_ptr;
    logic [LEN_W-1:0]        c_len;
    logic [SUM_W-1:0]        c_sum;
    logic [SUM_W-1:0]        work_sum;
    logic [PTR_W-1:0]        ptr_inc;
    logic [TOTAL_W:0]        tot_sum;
    logic                    take, load_out;

    logic                    wr_en, rd_en;
    logic [PTR_W-1:0]        wr_addr, rd_addr;
    logic [ELEMENT_BITS-1:0] wr_data, rd_data;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] p,
                                                    input logic [LEN_W-1:0] l);
        logic [LEN_W:0] s;
        s = (LEN_W + 1)'(p) + (LEN_W + 1)'(l);
        if (s >= WRAP)
        begin
            s = s - WRAP;
        end
        ring_slot = PTR_W'(s);
    endfunction

    function automatic logic at_limit(input logic [SUM_W-1:0] s,
                                      input logic [LIMIT_W-1:0] lim);
        at_limit = (CMP_W'(s) >= CMP_W'(lim));
    endfunction

    bwsc_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_window_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg.ready  = 1'b1;
    assign item.ready = (state_reg == ENG_IDLE);
    assign take       = item.valid && (state_reg == ENG_IDLE);

    assign result.valid           = out_valid_reg;
    assign result.ending_here     = out_len_reg;
    assign result.running_total   = out_total_reg;
    assign result.window_overflow = out_ovf_reg;

    assign c_ptr   = item.first ? '0 : ptr_reg;
    assign c_len   = item.first ? '0 : len_reg;
    assign c_sum   = item.first ? '0 : sum_reg;
    assign ptr_inc = next_ptr(ptr_reg);
    assign tot_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(len_reg);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_data        = elem_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        work_sum       = sum_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ENG_IDLE:
            begin
                if (take)
                begin
                    ptr_next   = c_ptr;
                    len_next   = c_len;
                    sum_next   = c_sum;
                    total_next = item.first ? '0 : total_reg;
                    ovf_next   = item.first ? 1'b0 : ovf_reg;
                    if (c_len == FULL_LEN)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = c_ptr;
                        state_next = ENG_FULL;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_slot(c_ptr, c_len);
                        wr_data  = item.element;
                        work_sum = c_sum + SUM_W'(item.element);
                        len_next = c_len + 1'b1;
                        sum_next = work_sum;
                        if (at_limit(work_sum, limit_reg))
                        begin
                            if (c_len == '0)
                            begin
                                // lone new element already too big
                                len_next   = '0;
                                sum_next   = '0;
                                ptr_next   = next_ptr(c_ptr);
                                state_next = ENG_FIN;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = c_ptr;
                                state_next = ENG_DROP;
                            end
                        end
                        else
                        begin
                            state_next = ENG_FIN;
                        end
                    end
                end
            end

            ENG_FULL:
            begin
                // drop oldest, new element takes its slot
                work_sum = sum_reg - SUM_W'(rd_data) + SUM_W'(elem_reg);
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = elem_reg;
                ptr_next = ptr_inc;
                sum_next = work_sum;
                ovf_next = 1'b1;
                if (at_limit(work_sum, limit_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_inc;
                    state_next = ENG_DROP;
                end
                else
                begin
                    state_next = ENG_FIN;
                end
            end

            ENG_DROP:
            begin
                work_sum = sum_reg - SUM_W'(rd_data);
                ptr_next = ptr_inc;
                len_next = len_reg - 1'b1;
                sum_next = work_sum;
                if ((len_next != '0) && at_limit(work_sum, limit_reg))
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_inc;
                end
                else
                begin
                    state_next = ENG_FIN;
                end
            end

            ENG_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    total_next     = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
                    state_next     = ENG_IDLE;
                end
            end

            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            ptr_reg       <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.sum_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            elem_reg <= item.element;
        end
        if (load_out)
        begin
            out_len_reg   <= len_reg;
            out_total_reg <= total_next;
            out_ovf_reg   <= ovf_reg;
        end
    end

endmodule

@@ hw/rtl/bounded_window_subarray_counter.sv @@
// Streaming count of contiguous subarrays with sum below sum_limit, by the sliding
// window method. Each element transfer yields one result: the window length after
// shrinking (subarrays ending here), a saturating 48-bit running total and a sticky
// overflow flag that is set once an element arrives at a full window of MAX_WINDOW
// entries. first=1 clears window, total and flag before the element is taken.
// An element is written to the window RAM or, if the window was full, over the
// oldest entry in a full step; each element dropped for reaching sum_limit adds a
// drop step. A lone element reaching sum_limit at an empty window needs no drop
// step. Drops run one per cycle through the RAM read port; the engine takes no new
// element until the last is done. A 2-entry queue takes transfers while it works,
// and a result register holds the finished result until it is taken. The user must
// write sum_limit only while the block is idle; the block does not enforce this.
module bounded_window_subarray_counter
    import bwsc_pkg::*;
#(
    parameter int MAX_WINDOW   = 1024,
    parameter int ELEMENT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    bwsc_in_if.sink    item,
    bwsc_out_if.source result,
    bwsc_cfg_if.sink   cfg
);

    bwsc_in_if #(.ELEMENT_BITS(ELEMENT_BITS)) queued ();

    bwsc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (item),
        .down  (queued.source)
    );

    bwsc_engine #(
        .MAX_WINDOW   (MAX_WINDOW),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (queued.sink),
        .result (result),
        .cfg    (cfg)
    );

endmodule

@@ hw/rtl/bwsc_checker.sv @@
`include "bounded_window_subarray_counter_macros.svh"

module bwsc_checker
    import bwsc_pkg::*;
#(
    parameter int MAX_WINDOW = 1024
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               res_valid,
    input logic                               res_ready,
    input logic [$clog2(MAX_WINDOW + 1)-1:0] ending_here,
    input logic [TOTAL_W-1:0]                 running_total,
    input logic                               window_overflow
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);

    `BWSC_ASSERT_NEXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(ending_here) && $stable(running_total) && $stable(window_overflow), "result changed while stalled")
    `BWSC_ASSERT_NOW(a_len_bound, res_valid, ending_here <= LEN_W'(MAX_WINDOW), "window length above MAX_WINDOW")
    `BWSC_ASSERT_NOW(a_total_covers, res_valid, running_total >= TOTAL_W'(ending_here), "running total below window length")

endmodule

bind bounded_window_subarray_counter bwsc_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_bwsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .ending_here     (result.ending_here),
    .running_total   (result.running_total),
    .window_overflow (result.window_overflow)
);

@@ sim/tb_bounded_window_subarray_counter.sv @@
`default_nettype none

module tb_bounded_window_subarray_counter;
    import bwsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN    = 1024;
    localparam int ELEM_W     = 16;
    localparam int LEN_W      = 11;
    localparam int STALL_LIMIT = 20000;
    localparam int OVF_RUN    = 1040;
    localparam int NUM_PHASES = 8;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              first;
    } element_xfer_t;

    typedef struct packed {
        logic [LEN_W-1:0]   ending_here;
        logic [TOTAL_W-1:0] running_total;
        logic               window_overflow;
    } subarray_count_t;

    logic clk = 1'b0;
    logic rst_n;

    bwsc_in_if #(.ELEMENT_BITS(ELEM_W)) item_ch ();
    bwsc_out_if #(.LEN_W(LEN_W))        res_ch ();
    bwsc_cfg_if                         cfg_ch ();

    bounded_window_subarray_counter #(
        .MAX_WINDOW   (MAX_WIN),
        .ELEMENT_BITS (ELEM_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    element_xfer_t   pending_elements[$];
    subarray_count_t expected_counts[$];

    // predictor state
    logic [ELEM_W-1:0]  win_ring [0:MAX_WIN-1];
    logic [9:0]         win_oldest;
    int unsigned        win_len;
    longint unsigned    win_sum;
    longint unsigned    total_subarrays;
    logic               overflow_flag;
    logic [LIMIT_W-1:0] limit_q;

    int errors;
    int accepted_items;
    int checked_results;
    int overflow_results;
    int max_len_seen;
    int limits_written;
    int stall_cycles;
    logic calm;

    assign calm = (accepted_items >= 300) && (accepted_items < 700);

    function automatic void drop_oldest_element();
        win_sum    -= win_ring[win_oldest];
        win_oldest += 10'd1;
        win_len--;
    endfunction

    function automatic void count_subarrays_ending_here(input logic [ELEM_W-1:0] elem,
                                                        input logic first_flag);
        subarray_count_t exp_cnt;
        logic [9:0]      slot;
        if (first_flag)
        begin
            win_oldest      = '0;
            win_len         = 0;
            win_sum         = 0;
            total_subarrays = 0;
            overflow_flag   = 1'b0;
        end
        if (win_len >= MAX_WIN)
        begin
            drop_oldest_element();
            overflow_flag = 1'b1;
        end
        slot           = 10'(int'(win_oldest) + win_len);
        win_ring[slot] = elem;
        win_len++;
        win_sum += elem;
        while (win_len > 0 && win_sum >= longint'(limit_q))
            drop_oldest_element();
        if (total_subarrays + win_len > longint'(TOTAL_MAX))
            total_subarrays = longint'(TOTAL_MAX);
        else
            total_subarrays += win_len;
        exp_cnt.ending_here     = LEN_W'(win_len);
        exp_cnt.running_total   = TOTAL_W'(total_subarrays);
        exp_cnt.window_overflow = overflow_flag;
        expected_counts.push_back(exp_cnt);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_element();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return '0;
        if (pick < 25)
            return '1;
        if (pick < 60)
            return ELEM_W'($urandom_range(0, 255));
        return ELEM_W'($urandom);
    endfunction

    // element driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.element <= '0;
            item_ch.first   <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                count_subarrays_ending_here(item_ch.element, item_ch.first);
                accepted_items++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_elements.size() != 0 && (calm || $urandom_range(0, 99) >= 31))
                begin
                    item_ch.valid   <= 1'b1;
                    item_ch.element <= pending_elements[0].element;
                    item_ch.first   <= pending_elements[0].first;
                    void'(pending_elements.pop_front());
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        subarray_count_t exp_cnt;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    errors++;
                end
                else
                begin
                    exp_cnt = expected_counts.pop_front();
                    checked_results++;
                    if (res_ch.window_overflow)
                        overflow_results++;
                    if (int'(res_ch.ending_here) > max_len_seen)
                        max_len_seen = int'(res_ch.ending_here);
                    if (res_ch.ending_here !== exp_cnt.ending_here)
                    begin
                        $error("ending_here: expected %0d, got %0d",
                               exp_cnt.ending_here, res_ch.ending_here);
                        errors++;
                    end
                    if (res_ch.running_total !== exp_cnt.running_total)
                    begin
                        $error("running_total: expected %0d, got %0d",
                               exp_cnt.running_total, res_ch.running_total);
                        errors++;
                    end
                    if (res_ch.window_overflow !== exp_cnt.window_overflow)
                    begin
                        $error("window_overflow: expected %0b, got %0b",
                               exp_cnt.window_overflow, res_ch.window_overflow);
                        errors++;
                    end
                end
            end
            res_ch.ready <= calm || ($urandom_range(0, 99) >= 31);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", stall_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_elements.size() != 0 || item_ch.valid || expected_counts.size() != 0);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.sum_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        limit_q = value;
        limits_written++;
    endtask

    task automatic push_element(input logic [ELEM_W-1:0] elem, input logic first_flag);
        element_xfer_t x;
        x.element = elem;
        x.first   = first_flag;
        pending_elements.push_back(x);
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        int                 n;
        errors           = 0;
        accepted_items   = 0;
        checked_results  = 0;
        overflow_results = 0;
        max_len_seen     = 0;
        limits_written   = 0;
        stall_cycles     = 0;
        win_oldest       = '0;
        win_len          = 0;
        win_sum          = 0;
        total_subarrays  = 0;
        overflow_flag    = 1'b0;
        limit_q          = '0;
        rst_n            <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.sum_limit <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // zero threshold at reset: nothing qualifies
        push_element(16'd0, 1'b1);
        push_element(16'hFFFF, 1'b0);
        push_element(16'd1, 1'b0);
        push_element(16'd0, 1'b0);
        wait_idle();

        // only zero-sum subarrays qualify
        write_limit(32'd1);
        push_element(16'd0, 1'b1);
        push_element(16'd0, 1'b0);
        push_element(16'd0, 1'b0);
        push_element(16'd1, 1'b0);
        push_element(16'd0, 1'b0);
        wait_idle();

        write_limit(32'd65536);
        push_element(16'hFFFF, 1'b1);
        push_element(16'd1, 1'b0);
        push_element(16'd0, 1'b0);
        push_element(16'hFFFF, 1'b0);
        push_element(16'h8000, 1'b1);
        push_element(16'h7FFF, 1'b0);
        push_element(16'h5555, 1'b0);
        push_element(16'hAAAA, 1'b0);
        wait_idle();

        // max threshold: the window never shrinks, so it fills and wraps
        write_limit(32'hFFFF_FFFF);
        push_element(16'hFFFF, 1'b1);
        for (int i = 1; i < OVF_RUN; i++)
            push_element(rand_element(), 1'b0);
        push_element(16'd7, 1'b1);
        push_element(16'hFFFF, 1'b0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 6)
                0: lim = LIMIT_W'($urandom_range(1, 512));
                1: lim = LIMIT_W'($urandom_range(512, 70000));
                2: lim = LIMIT_W'($urandom_range(70000, 2000000));
                3: lim = LIMIT_W'($urandom);
                4: lim = '0;
                default: lim = '1;
            endcase
            write_limit(lim);
            n = $urandom_range(25, 45);
            push_element(rand_element(), 1'b1);
            for (int i = 1; i < n; i++)
                push_element(rand_element(), ($urandom_range(0, 15) == 0));
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("%0d elements in, %0d results checked over %0d sum_limit settings",
                 accepted_items, checked_results, limits_written);
        $display("longest window %0d, %0d results with window overflow set",
                 max_len_seen, overflow_results);
        if (errors == 0 && expected_counts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
